// ===== src/vt2d_pkg.sv =====
`timescale 1ns / 1ps

package vt2d_pkg;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 16;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // product of a coordinate and a coefficient, and one guard bit for sums
    localparam int PROD_W = COORD_W + COEF_W;
    localparam int SUM_W  = PROD_W + 1;
    // widest value that reaches the saturation stage
    localparam int SAT_W  = 41;

    localparam logic [OP_W-1:0] OP_TRANSLATE = 3'd0;
    localparam logic [OP_W-1:0] OP_ROTATE    = 3'd1;
    localparam logic [OP_W-1:0] OP_SCALE     = 3'd2;
    localparam logic [OP_W-1:0] OP_SHEAR     = 3'd3;
    localparam logic [OP_W-1:0] OP_REFLECT   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_X  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_Y  = 3'd7;

    localparam logic signed [COORD_W-1:0] RST_OFFSET_X = 32'sd1310720;
    localparam logic signed [COORD_W-1:0] RST_OFFSET_Y = 32'sd1310720;
    localparam logic signed [COEF_W-1:0]  RST_ROT_COS  = -16'sd8192;
    localparam logic signed [COEF_W-1:0]  RST_ROT_SIN  = 16'sd14189;
    localparam logic signed [COEF_W-1:0]  RST_SCALE_X  = 16'sd384;
    localparam logic signed [COEF_W-1:0]  RST_SCALE_Y  = 16'sd384;
    localparam logic signed [COEF_W-1:0]  RST_SHEAR_X  = 16'sd128;
    localparam logic signed [COEF_W-1:0]  RST_SHEAR_Y  = 16'sd0;

    typedef struct packed {
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic signed [COEF_W-1:0]  rot_cos;
        logic signed [COEF_W-1:0]  rot_sin;
        logic signed [COEF_W-1:0]  scale_x;
        logic signed [COEF_W-1:0]  scale_y;
        logic signed [COEF_W-1:0]  shear_x;
        logic signed [COEF_W-1:0]  shear_y;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] val;
        logic                      ovf;
    } t_sat;

    // clamp to the signed coordinate range
    function automatic t_sat sat_coord(input logic signed [SAT_W-1:0] v);
        t_sat r;
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(2147483647);
        lo = ~hi;
        if (v > hi) begin
            r.val = 32'sh7fffffff;
            r.ovf = 1'b1;
        end else if (v < lo) begin
            r.val = 32'sh80000000;
            r.ovf = 1'b1;
        end else begin
            r.val = v[COORD_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/vt2d_in_if.sv =====
`timescale 1ns / 1ps

interface vt2d_in_if;
    import vt2d_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           req_type;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;

    modport source (output valid, req_type, x_in, y_in, input ready);
    modport sink   (input valid, req_type, x_in, y_in, output ready);
endinterface

// ===== src/vt2d_out_if.sv =====
`timescale 1ns / 1ps

interface vt2d_out_if;
    import vt2d_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic                      overflow;

    modport source (output valid, x_out, y_out, overflow, input ready);
    modport sink   (input valid, x_out, y_out, overflow, output ready);
endinterface

// ===== src/vt2d_cfg_if.sv =====
`timescale 1ns / 1ps

interface vt2d_cfg_if;
    import vt2d_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/vt2d_cfg_regs.sv =====
`timescale 1ns / 1ps

module vt2d_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vt2d_cfg_if.sink        i_cfg,
    output vt2d_pkg::t_cfg  o_cfg
);
    import vt2d_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x <= RST_OFFSET_X;
            r_cfg.offset_y <= RST_OFFSET_Y;
            r_cfg.rot_cos  <= RST_ROT_COS;
            r_cfg.rot_sin  <= RST_ROT_SIN;
            r_cfg.scale_x  <= RST_SCALE_X;
            r_cfg.scale_y  <= RST_SCALE_Y;
            r_cfg.shear_x  <= RST_SHEAR_X;
            r_cfg.shear_y  <= RST_SHEAR_Y;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_OFFSET_X: r_cfg.offset_x <= i_cfg.data;
                CFG_OFFSET_Y: r_cfg.offset_y <= i_cfg.data;
                CFG_ROT_COS:  r_cfg.rot_cos  <= i_cfg.data[COEF_W-1:0];
                CFG_ROT_SIN:  r_cfg.rot_sin  <= i_cfg.data[COEF_W-1:0];
                CFG_SCALE_X:  r_cfg.scale_x  <= i_cfg.data[COEF_W-1:0];
                CFG_SCALE_Y:  r_cfg.scale_y  <= i_cfg.data[COEF_W-1:0];
                CFG_SHEAR_X:  r_cfg.shear_x  <= i_cfg.data[COEF_W-1:0];
                CFG_SHEAR_Y:  r_cfg.shear_y  <= i_cfg.data[COEF_W-1:0];
                default: ;
            endcase
        end
    end
endmodule

// ===== src/vertex_transform_2d.sv =====
`timescale 1ns / 1ps

// 2D affine transform of a stream of Q16.16 vertices.
// i_vtx carries one vertex and an op code per beat (translate, rotate, scale,
// shear, reflect about y; other codes pass the vertex through). o_vtx returns
// the transformed vertex, saturated to 32 bits, with an overflow flag.
// i_cfg writes the offsets and Q2.14 / Q8.8 coefficients by index; it is
// always ready. The user must write it only while no vertex is in flight;
// the block does not enforce this. Throughput: one vertex per cycle while
// o_vtx is not stalled. Five register stages: input capture, coefficient
// multiply, x result (and y for all but shear), shear y multiply on the
// saturated new x, then the output register.
// Stall: the whole pipe holds while o_vtx.valid is high and o_vtx.ready is
// low; i_vtx.ready drops in the same cycle, so nothing is lost or repeated.
// Reset: all stage valids clear, config registers take RST_ defaults.
module vertex_transform_2d (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vt2d_in_if.sink   i_vtx,
    vt2d_cfg_if.sink  i_cfg,
    vt2d_out_if.source o_vtx
);
    import vt2d_pkg::*;

    t_cfg cfg;

    vt2d_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    logic adv;

    // stage 1: capture
    logic                      r1_v;
    logic [OP_W-1:0]           r1_op;
    logic signed [COORD_W-1:0] r1_x;
    logic signed [COORD_W-1:0] r1_y;

    // stage 2: products
    logic                      r2_v;
    logic [OP_W-1:0]           r2_op;
    logic signed [COORD_W-1:0] r2_x;
    logic signed [COORD_W-1:0] r2_y;
    logic signed [PROD_W-1:0]  r2_m0;
    logic signed [PROD_W-1:0]  r2_m1;
    logic signed [PROD_W-1:0]  r2_m2;
    logic signed [PROD_W-1:0]  r2_m3;

    // stage 3: x result
    logic                      r3_v;
    logic                      r3_shear;
    logic signed [COORD_W-1:0] r3_nx;
    logic signed [COORD_W-1:0] r3_ny;
    logic                      r3_ovf;

    // stage 4: shear y product
    logic                      r4_v;
    logic                      r4_shear;
    logic signed [COORD_W-1:0] r4_nx;
    logic signed [COORD_W-1:0] r4_ny;
    logic                      r4_ovf;
    logic signed [PROD_W-1:0]  r4_m;

    // stage 5: output
    logic                      r5_v;
    logic signed [COORD_W-1:0] r5_x;
    logic signed [COORD_W-1:0] r5_y;
    logic                      r5_ovf;

    assign adv         = !r5_v || o_vtx.ready;
    assign i_vtx.ready = adv;

    assign o_vtx.valid    = r5_v;
    assign o_vtx.x_out    = r5_x;
    assign o_vtx.y_out    = r5_y;
    assign o_vtx.overflow = r5_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_vtx.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_op <= i_vtx.req_type;
            r1_x  <= i_vtx.x_in;
            r1_y  <= i_vtx.y_in;
        end
    end

    // coefficient selection per op
    logic signed [COEF_W-1:0] k0;
    logic signed [COEF_W-1:0] k1;
    logic signed [COEF_W-1:0] k2;
    logic signed [COEF_W-1:0] k3;

    always_comb begin
        k0 = cfg.rot_cos;
        k1 = cfg.rot_sin;
        k2 = cfg.rot_sin;
        k3 = cfg.rot_cos;
        unique case (r1_op)
            OP_SCALE: begin
                k0 = cfg.scale_x;
                k3 = cfg.scale_y;
            end
            OP_SHEAR: begin
                k1 = cfg.shear_x;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_op <= r1_op;
            r2_x  <= r1_x;
            r2_y  <= r1_y;
            r2_m0 <= PROD_W'(r1_x) * PROD_W'(k0);
            r2_m1 <= PROD_W'(r1_y) * PROD_W'(k1);
            r2_m2 <= PROD_W'(r1_x) * PROD_W'(k2);
            r2_m3 <= PROD_W'(r1_y) * PROD_W'(k3);
        end
    end

    // stage 3 arithmetic
    logic signed [SUM_W-1:0] e0;
    logic signed [SUM_W-1:0] e1;
    logic signed [SUM_W-1:0] e2;
    logic signed [SUM_W-1:0] e3;
    logic signed [SUM_W-1:0] ex;
    logic signed [SUM_W-1:0] rot_x;
    logic signed [SUM_W-1:0] rot_y;
    logic signed [SUM_W-1:0] scl_x;
    logic signed [SUM_W-1:0] scl_y;
    logic signed [SUM_W-1:0] shr_x;
    logic signed [SAT_W-1:0] xw;
    logic signed [SAT_W-1:0] yw;
    logic signed [SAT_W-1:0] pre_x;
    logic signed [SAT_W-1:0] pre_y;
    t_sat                    sat_x;
    t_sat                    sat_y;

    assign e0 = SUM_W'(r2_m0);
    assign e1 = SUM_W'(r2_m1);
    assign e2 = SUM_W'(r2_m2);
    assign e3 = SUM_W'(r2_m3);
    assign ex = SUM_W'(r2_x);
    assign xw = SAT_W'(r2_x);
    assign yw = SAT_W'(r2_y);

    // round half up: add half an LSB, then arithmetic shift
    assign rot_x = (e0 - e1 + SUM_W'(8192)) >>> 14;
    assign rot_y = (e2 + e3 + SUM_W'(8192)) >>> 14;
    assign scl_x = (e0 + SUM_W'(128)) >>> 8;
    assign scl_y = (e3 + SUM_W'(128)) >>> 8;
    assign shr_x = ((ex <<< 8) + e1 + SUM_W'(128)) >>> 8;

    always_comb begin
        pre_x = xw;
        pre_y = yw;
        unique case (r2_op)
            OP_TRANSLATE: begin
                pre_x = xw + SAT_W'(cfg.offset_x);
                pre_y = yw + SAT_W'(cfg.offset_y);
            end
            OP_ROTATE: begin
                pre_x = $signed(rot_x[SAT_W-1:0]);
                pre_y = $signed(rot_y[SAT_W-1:0]);
            end
            OP_SCALE: begin
                pre_x = $signed(scl_x[SAT_W-1:0]);
                pre_y = $signed(scl_y[SAT_W-1:0]);
            end
            OP_SHEAR: begin
                pre_x = $signed(shr_x[SAT_W-1:0]);
            end
            OP_REFLECT: begin
                pre_x = -xw;
            end
            default: ;
        endcase
        sat_x = sat_coord(pre_x);
        sat_y = sat_coord(pre_y);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_shear <= (r2_op == OP_SHEAR);
            r3_nx    <= sat_x.val;
            r3_ny    <= sat_y.val;
            r3_ovf   <= sat_x.ovf | sat_y.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_shear <= r3_shear;
            r4_nx    <= r3_nx;
            r4_ny    <= r3_ny;
            r4_ovf   <= r3_ovf;
            r4_m     <= PROD_W'(r3_nx) * PROD_W'(cfg.shear_y);
        end
    end

    // shear y from the saturated new x
    logic signed [SUM_W-1:0] ey;
    logic signed [SUM_W-1:0] em;
    logic signed [SUM_W-1:0] shr_y;
    t_sat                    sat_sy;

    assign ey     = SUM_W'(r4_ny);
    assign em     = SUM_W'(r4_m);
    assign shr_y  = ((ey <<< 8) + em + SUM_W'(128)) >>> 8;
    assign sat_sy = sat_coord($signed(shr_y[SAT_W-1:0]));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_x <= r4_nx;
            if (r4_shear) begin
                r5_y   <= sat_sy.val;
                r5_ovf <= r4_ovf | sat_sy.ovf;
            end else begin
                r5_y   <= r4_ny;
                r5_ovf <= r4_ovf;
            end
        end
    end
endmodule

// ===== tb/vt2d_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels of vertex_transform_2d, predicts every result
// beat from the accepted input beats and compares them in order.
module vt2d_checker
    import vt2d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    vt2d_in_if   i_vtx,
    vt2d_cfg_if  i_cfg,
    vt2d_out_if  i_vtx_out,
    output int   o_mismatches,
    output int   o_outstanding
);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      ovf;
    } t_vtx_result;

    localparam longint COORD_HI = 64'sd2147483647;
    localparam longint COORD_LO = -64'sd2147483648;

    t_cfg        coefs;
    t_vtx_result pending_results[$];

    // add half an LSB, then floor
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic t_vtx_result transform_vertex(
        input logic [OP_W-1:0]         op,
        input logic signed [COORD_W-1:0] x_in,
        input logic signed [COORD_W-1:0] y_in,
        input t_cfg                    c
    );
        t_vtx_result r;
        longint xv, yv, nx_raw, ny_raw;
        longint ox, oy, cs, sn, sx, sy, hx, hy;
        xv = x_in;
        yv = y_in;
        ox = $signed(c.offset_x);
        oy = $signed(c.offset_y);
        cs = $signed(c.rot_cos);
        sn = $signed(c.rot_sin);
        sx = $signed(c.scale_x);
        sy = $signed(c.scale_y);
        hx = $signed(c.shear_x);
        hy = $signed(c.shear_y);
        nx_raw = xv;
        ny_raw = yv;
        case (op)
            OP_TRANSLATE: begin
                nx_raw = xv + ox;
                ny_raw = yv + oy;
            end
            OP_ROTATE: begin
                nx_raw = round_half_up(xv * cs - yv * sn, 14);
                ny_raw = round_half_up(xv * sn + yv * cs, 14);
            end
            OP_SCALE: begin
                nx_raw = round_half_up(xv * sx, 8);
                ny_raw = round_half_up(yv * sy, 8);
            end
            OP_SHEAR: begin
                nx_raw = round_half_up(xv * 256 + hx * yv, 8);
                // y uses the already saturated new x
                ny_raw = round_half_up(yv * 256 + hy * clamp_coord(nx_raw), 8);
            end
            OP_REFLECT: begin
                nx_raw = -xv;
            end
            default: ;
        endcase
        r.x   = COORD_W'(clamp_coord(nx_raw));
        r.y   = COORD_W'(clamp_coord(ny_raw));
        r.ovf = (clamp_coord(nx_raw) != nx_raw) || (clamp_coord(ny_raw) != ny_raw);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_vtx_result want;
        if (!i_rst_n) begin
            coefs.offset_x = RST_OFFSET_X;
            coefs.offset_y = RST_OFFSET_Y;
            coefs.rot_cos  = RST_ROT_COS;
            coefs.rot_sin  = RST_ROT_SIN;
            coefs.scale_x  = RST_SCALE_X;
            coefs.scale_y  = RST_SCALE_Y;
            coefs.shear_x  = RST_SHEAR_X;
            coefs.shear_y  = RST_SHEAR_Y;
            pending_results.delete();
            o_mismatches  = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_OFFSET_X: coefs.offset_x = i_cfg.data;
                    CFG_OFFSET_Y: coefs.offset_y = i_cfg.data;
                    CFG_ROT_COS:  coefs.rot_cos  = i_cfg.data[COEF_W-1:0];
                    CFG_ROT_SIN:  coefs.rot_sin  = i_cfg.data[COEF_W-1:0];
                    CFG_SCALE_X:  coefs.scale_x  = i_cfg.data[COEF_W-1:0];
                    CFG_SCALE_Y:  coefs.scale_y  = i_cfg.data[COEF_W-1:0];
                    CFG_SHEAR_X:  coefs.shear_x  = i_cfg.data[COEF_W-1:0];
                    CFG_SHEAR_Y:  coefs.shear_y  = i_cfg.data[COEF_W-1:0];
                    default: ;
                endcase
            end
            if (i_vtx_out.valid && i_vtx_out.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no vertex outstanding");
                    o_mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_vtx_out.x_out !== want.x) begin
                        $error("x_out: expected %0d, got %0d", want.x, i_vtx_out.x_out);
                        o_mismatches++;
                    end
                    if (i_vtx_out.y_out !== want.y) begin
                        $error("y_out: expected %0d, got %0d", want.y, i_vtx_out.y_out);
                        o_mismatches++;
                    end
                    if (i_vtx_out.overflow !== want.ovf) begin
                        $error("overflow: expected %0d, got %0d", want.ovf,
                               i_vtx_out.overflow);
                        o_mismatches++;
                    end
                end
            end
            if (i_vtx.valid && i_vtx.ready) begin
                pending_results.push_back(
                    transform_vertex(i_vtx.req_type, i_vtx.x_in, i_vtx.y_in, coefs));
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

// ===== tb/vertex_transform_2d_tb.sv =====
`timescale 1ns / 1ps

module vertex_transform_2d_tb;
    import vt2d_pkg::*;

    localparam int PIPE_DEPTH  = 5;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int IDLE_PCT    = 24;
    localparam int PHASE_ITEMS = 125;

    localparam logic signed [COORD_W-1:0] XY_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] XY_MIN = 32'sh8000_0000;
    localparam logic signed [COEF_W-1:0]  K_MAX  = 16'sh7fff;
    localparam logic signed [COEF_W-1:0]  K_MIN  = 16'sh8000;
    // codes above reflect pass the vertex through
    localparam logic [OP_W-1:0] OP_PASS_FIRST = OP_REFLECT + 3'd1;
    localparam logic [OP_W-1:0] OP_PASS_LAST  = '1;

    logic i_clk;
    logic i_rst_n;
    bit   steady;
    int   cycles = 0;
    int   mismatches;
    int   outstanding;

    vt2d_in_if  vtx_in ();
    vt2d_out_if vtx_out ();
    vt2d_cfg_if cfg_bus ();

    vertex_transform_2d uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_in),
        .i_cfg   (cfg_bus),
        .o_vtx   (vtx_out)
    );

    vt2d_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vtx         (vtx_in),
        .i_cfg         (cfg_bus),
        .i_vtx_out     (vtx_out),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        vtx_out.ready <= i_rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return XY_MAX;
                    1: return XY_MIN;
                    2: return '0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            1, 2: return $urandom_range(0, 2 ** 21) - 2 ** 20;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return K_MAX;
            1: return K_MIN;
            2: return '0;
            3, 4: return COEF_W'($urandom_range(0, 1024) - 512);
            default: return COEF_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_offset();
        case ($urandom_range(0, 4))
            0: return XY_MAX;
            1: return XY_MIN;
            2, 3: return $urandom_range(0, 2 ** 24) - 2 ** 23;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_cfg random_setup();
        t_cfg c;
        c.offset_x = pick_offset();
        c.offset_y = pick_offset();
        c.rot_cos  = pick_coef();
        c.rot_sin  = pick_coef();
        c.scale_x  = pick_coef();
        c.scale_y  = pick_coef();
        c.shear_x  = pick_coef();
        c.shear_y  = pick_coef();
        return c;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_vertex(input logic [OP_W-1:0] op,
                               input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            vtx_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        vtx_in.valid    <= 1'b1;
        vtx_in.req_type <= op;
        vtx_in.x_in     <= x;
        vtx_in.y_in     <= y;
        @(posedge i_clk);
        while (!vtx_in.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [OP_W-1:0] op;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                op = OP_W'($urandom_range(OP_PASS_FIRST, OP_PASS_LAST));
            end else begin
                op = OP_W'($urandom_range(OP_TRANSLATE, OP_REFLECT));
            end
            send_vertex(op, pick_coord(), pick_coord());
        end
    endtask

    task automatic settle();
        vtx_in.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 3) @(negedge i_clk);
    endtask

    // valid stays high across back-to-back register beats
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        settle();
        // junk in the upper half of coefficient writes must be ignored
        write_reg(CFG_OFFSET_X, c.offset_x);
        write_reg(CFG_OFFSET_Y, c.offset_y);
        write_reg(CFG_ROT_COS, {16'($urandom()), c.rot_cos});
        write_reg(CFG_ROT_SIN, {16'($urandom()), c.rot_sin});
        write_reg(CFG_SCALE_X, {16'($urandom()), c.scale_x});
        write_reg(CFG_SCALE_Y, {16'($urandom()), c.scale_y});
        write_reg(CFG_SHEAR_X, {16'($urandom()), c.shear_x});
        write_reg(CFG_SHEAR_Y, {16'($urandom()), c.shear_y});
        cfg_bus.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        t_cfg setup;
        i_rst_n          <= 1'b0;
        steady           = 1'b0;
        vtx_in.valid     <= 1'b0;
        vtx_in.req_type  <= OP_TRANSLATE;
        vtx_in.x_in      <= '0;
        vtx_in.y_in      <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= CFG_OFFSET_X;
        cfg_bus.data     <= '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed vertices on the reset coefficients
        send_vertex(OP_TRANSLATE, XY_MAX, XY_MAX);
        send_vertex(OP_TRANSLATE, XY_MIN, XY_MIN);
        send_vertex(OP_TRANSLATE, '0, '0);
        send_vertex(OP_ROTATE, XY_MAX, XY_MIN);
        send_vertex(OP_ROTATE, XY_MIN, XY_MAX);
        send_vertex(OP_ROTATE, XY_MAX, XY_MAX);
        send_vertex(OP_ROTATE, 1, 1);
        send_vertex(OP_SCALE, XY_MAX, XY_MIN);
        send_vertex(OP_SCALE, -1, 1);
        send_vertex(OP_SCALE, 1, -1);
        send_vertex(OP_SHEAR, XY_MAX, XY_MAX);
        send_vertex(OP_SHEAR, XY_MIN, 1);
        send_vertex(OP_REFLECT, XY_MIN, 5);     // negating the most negative x saturates
        send_vertex(OP_REFLECT, XY_MAX, XY_MIN);
        send_vertex(OP_REFLECT, '0, -1);
        send_vertex(OP_PASS_FIRST, XY_MIN, XY_MAX);
        send_vertex(OP_PASS_FIRST + 3'd1, XY_MAX, XY_MIN);
        send_vertex(OP_PASS_LAST, -1, '0);

        setup = '{offset_x: XY_MAX, offset_y: XY_MAX, rot_cos: K_MAX, rot_sin: K_MAX,
                  scale_x: K_MAX, scale_y: K_MAX, shear_x: K_MAX, shear_y: K_MAX};
        load_config(setup);
        send_random(PHASE_ITEMS);

        setup = '{offset_x: XY_MIN, offset_y: XY_MIN, rot_cos: K_MIN, rot_sin: K_MIN,
                  scale_x: K_MIN, scale_y: K_MIN, shear_x: K_MIN, shear_y: K_MIN};
        load_config(setup);
        send_random(PHASE_ITEMS);

        // identity coefficients, full rate on both sides
        setup = '{offset_x: '0, offset_y: '0, rot_cos: 16'sd16384, rot_sin: '0,
                  scale_x: 16'sd256, scale_y: 16'sd256, shear_x: '0, shear_y: '0};
        load_config(setup);
        steady = 1'b1;
        send_random(PHASE_ITEMS);
        steady = 1'b0;

        repeat (7) begin
            load_config(random_setup());
            send_random(PHASE_ITEMS);
        end

        settle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
